// File: hw/rtl/lmsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsf_pkg
// Shared types and constants for the LMS adaptive FIR filter.
// ----------------------------------------------------------------------------
package lmsf_pkg;

    // register map (index = byte address / 4)
    localparam int          PADDR_W       = 3;
    localparam logic        REG_STEP_SIZE = 1'b0;
    localparam logic [15:0] STEP_RESET    = 16'd655;

    // fixed-point widths
    localparam int MUE_W  = 34;   // step * error
    localparam int PROD_W = 50;   // shared multiplier output

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_RESULT,
        ST_MU,
        ST_EMIT,
        ST_UPD
    } lmsf_state_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic acc_clr;  // clear accumulator for a new word
        logic res_ld;   // latch filter output and error
        logic mu_ld;    // latch step * error
        logic upd;      // weight update pass active
    } lmsf_dp_ctl_t;

endpackage

// File: hw/rtl/lmsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lmsf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsf_datapath
// Shared multiplier pipeline: dot-product accumulate, output rounding and
// saturation, and the rounded, saturated weight update.
// ----------------------------------------------------------------------------
module lmsf_datapath
    import lmsf_pkg::*;
#(
    parameter int TAPS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lmsf_dp_ctl_t                           ctl,
    input  logic                                   rd_valid,
    input  logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] rd_idx,
    input  logic signed [15:0]                     tap,
    input  logic signed [31:0]                     weight,
    input  logic signed [15:0]                     desired,
    input  logic [15:0]                            step,
    output logic                                   busy,
    output logic signed [15:0]                     y,
    output logic signed [16:0]                     err,
    output logic                                   wr_en,
    output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] wr_idx,
    output logic [31:0]                            wr_data
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int ACC_W = PROD_W + CNT_W;
    localparam int SH_W  = ACC_W - 28;
    localparam logic signed [SH_W-1:0] Y_MAX = SH_W'(32767);
    localparam logic signed [SH_W-1:0] Y_MIN = -SH_W'(32768);

    logic signed [MUE_W-1:0]  op_a;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [SH_W-1:0]   acc_sh;
    logic signed [15:0]       y_c;
    logic signed [32:0]       wsum;

    logic                     va_reg;
    logic [AW-1:0]            a_idx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       a_w_reg;
    logic                     vb_reg;
    logic [AW-1:0]            b_idx_reg;
    logic signed [31:0]       rnd_reg;
    logic signed [31:0]       b_w_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [MUE_W-1:0]  mu_err_reg;
    logic signed [15:0]       y_reg;
    logic signed [16:0]       err_reg;

    // one multiplier: weight * tap on the dot pass, (mu * err) * tap on update
    always_comb begin
        op_a   = ctl.upd ? mu_err_reg : {{(MUE_W - 32){weight[31]}}, weight};
        prod_c = op_a * tap;
    end

    // add 2^17, floor by 2^18
    assign rnd_sum = prod_reg + PROD_W'(131072);

    // filter output: add 2^27, floor by 2^28, clamp to 16 bits
    always_comb begin
        acc_rnd = acc_reg + (ACC_W'(1) << 27);
        acc_sh  = acc_rnd[ACC_W-1:28];
        if (acc_sh > Y_MAX) begin
            y_c = 16'sd32767;
        end else if (acc_sh < Y_MIN) begin
            y_c = -16'sd32768;
        end else begin
            y_c = acc_sh[15:0];
        end
    end

    // weight plus correction, clamped to 32 bits
    always_comb begin
        wsum = {b_w_reg[31], b_w_reg} + {rnd_reg[31], rnd_reg};
        if (wsum[32] != wsum[31]) begin
            wr_data = wsum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            wr_data = wsum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            va_reg <= rd_valid;
            vb_reg <= va_reg & ctl.upd;
        end
    end

    always_ff @(posedge aclk) begin
        a_idx_reg <= rd_idx;
        prod_reg  <= prod_c;
        a_w_reg   <= weight;
        b_idx_reg <= a_idx_reg;
        rnd_reg   <= rnd_sum[PROD_W-1:18];
        b_w_reg   <= a_w_reg;
        if (ctl.acc_clr) begin
            acc_reg <= '0;
        end else if (va_reg && !ctl.upd) begin
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (ctl.res_ld) begin
            y_reg   <= y_c;
            err_reg <= {desired[15], desired} - {y_c[15], y_c};
        end
        if (ctl.mu_ld) begin
            mu_err_reg <= $signed({1'b0, step}) * err_reg;
        end
    end

    assign busy   = va_reg | vb_reg;
    assign wr_en  = vb_reg;
    assign wr_idx = b_idx_reg;
    assign y      = y_reg;
    assign err    = err_reg;

endmodule

// File: hw/rtl/lms_adaptive_fir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_adaptive_fir
// LMS adaptive FIR filter: delay line and weights in RAM, one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word = sample_in plus desired_in (both Q1.15). The sample
//   is pushed into a TAPS-deep delay line held as a circular buffer in RAM.
//   m_ channel: one word per input word = filter_out (Q1.15, saturated, from
//   the weights before update) and error_out = desired - filter_out.
//   APB port: step_size (Q0.16) at byte address 0, reset value 655.
//   Write it only while the filter is idle.
// Operation:
//   Each word takes one RAM read per tap for the dot product, then one
//   per tap for the weight update, both through the same multiplier.
//   One word is in work at a time.
// Reset:
//   Both stores read as zero after reset via per-entry valid flags, so no
//   clearing pass is needed; step_size returns to 655.
// Backpressure:
//   The result sits in an output register, so a new input word is taken
//   while it waits. If the previous result is still unread when the next
//   one is ready, the filter holds before the update pass until m_ready.
// ----------------------------------------------------------------------------
module lms_adaptive_fir
    import lmsf_pkg::*;
#(
    parameter int TAPS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input words
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_sample_in,
    input  logic signed [15:0]  s_desired_in,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_filter_out,
    output logic signed [16:0]  m_error_out,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W = $clog2(TAPS + 1);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(TAPS - 1);
    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(TAPS);

    lmsf_state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]      daddr_reg, daddr_next;   // delay-line read pointer
    logic [AW-1:0]      head_reg, head_next;     // physical slot of newest tap
    logic [AW-1:0]      head_dec;
    logic [TAPS-1:0]    dvalid_reg;
    logic [TAPS-1:0]    wvalid_reg;
    logic               dvld_q_reg;
    logic               wvld_q_reg;
    logic               issue;
    logic               issue_q_reg;
    logic [AW-1:0]      ridx_q_reg;
    logic [AW-1:0]      w_raddr;
    logic               accept;
    logic               out_load;
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_filter_out_reg;
    logic signed [16:0] m_error_out_reg;
    logic signed [15:0] desired_reg;
    logic [15:0]        step_reg;
    logic               cfg_wr;

    logic [15:0]        d_rdata;
    logic [31:0]        w_rdata;
    logic signed [15:0] tap_m;
    logic signed [31:0] weight_m;

    lmsf_dp_ctl_t       dp_ctl;
    logic               dp_busy;
    logic signed [15:0] dp_y;
    logic signed [16:0] dp_err;
    logic               dp_wr_en;
    logic [AW-1:0]      dp_wr_idx;
    logic [31:0]        dp_wr_data;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[PADDR_W-1:2] == REG_STEP_SIZE) ? {16'h0000, step_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
        end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_STEP_SIZE) begin
            step_reg <= pwdata[15:0];
        end
    end

    // ---------------- handshakes ----------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign issue    = (state_reg == ST_DOT || state_reg == ST_UPD) && (cnt_reg != CNT_END);
    assign head_dec = (head_reg == '0) ? LAST_ADDR : head_reg - AW'(1);
    assign w_raddr  = issue ? cnt_reg[AW-1:0] : '0;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        daddr_next = daddr_reg;
        dp_ctl     = '0;
        dp_ctl.upd = (state_reg == ST_UPD);

        if (issue) begin
            cnt_next   = cnt_reg + CNT_W'(1);
            daddr_next = (daddr_reg == LAST_ADDR) ? '0 : daddr_reg + AW'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    head_next      = head_dec;
                    daddr_next     = head_dec;
                    cnt_next       = '0;
                    dp_ctl.acc_clr = 1'b1;
                    state_next     = ST_DOT;
                end
            end
            ST_DOT: begin
                if (cnt_reg == CNT_END && !issue_q_reg && !dp_busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                dp_ctl.res_ld = 1'b1;
                state_next    = ST_MU;
            end
            ST_MU: begin
                dp_ctl.mu_ld = 1'b1;
                cnt_next     = '0;
                daddr_next   = head_reg;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (cnt_reg == CNT_END && !issue_q_reg && !dp_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            cnt_reg     <= '0;
            daddr_reg   <= '0;
            issue_q_reg <= 1'b0;
            dvalid_reg  <= '0;
            wvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            daddr_reg   <= daddr_next;
            issue_q_reg <= issue;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                dvalid_reg[head_dec] <= 1'b1;
            end
            if (dp_wr_en) begin
                wvalid_reg[dp_wr_idx] <= 1'b1;
            end
        end
    end

    // read-side flags travel with the registered RAM data
    always_ff @(posedge aclk) begin
        dvld_q_reg <= dvalid_reg[daddr_reg];
        wvld_q_reg <= wvalid_reg[w_raddr];
        ridx_q_reg <= w_raddr;
        if (accept) begin
            desired_reg <= s_desired_in;
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_filter_out_reg <= dp_y;
            m_error_out_reg  <= dp_err;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filter_out = m_filter_out_reg;
    assign m_error_out  = m_error_out_reg;

    // ---------------- stores ----------------
    lmsf_ram #(
        .WIDTH (16),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (head_dec),
        .wdata (s_sample_in),
        .raddr (daddr_reg),
        .rdata (d_rdata)
    );

    lmsf_ram #(
        .WIDTH (32),
        .DEPTH (TAPS)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (dp_wr_en),
        .waddr (dp_wr_idx),
        .wdata (dp_wr_data),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // never-written entries read as zero
    assign tap_m    = dvld_q_reg ? $signed(d_rdata) : 16'sd0;
    assign weight_m = wvld_q_reg ? $signed(w_rdata) : 32'sd0;

    // ---------------- arithmetic ----------------
    lmsf_datapath #(
        .TAPS (TAPS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dp_ctl),
        .rd_valid (issue_q_reg),
        .rd_idx   (ridx_q_reg),
        .tap      (tap_m),
        .weight   (weight_m),
        .desired  (desired_reg),
        .step     (step_reg),
        .busy     (dp_busy),
        .y        (dp_y),
        .err      (dp_err),
        .wr_en    (dp_wr_en),
        .wr_idx   (dp_wr_idx),
        .wr_data  (dp_wr_data)
    );

endmodule
